### rtl/vn_pkg.sv
// Package for the 3D vector normalizer: widths, stage counts and shared types.
// Used by every rtl module except vn_checker; depends on nothing.
package vn_pkg;

    localparam int CompWidth   = 32;
    localparam int SqWidth     = 2 * CompWidth;
    localparam int ThreshWidth = 17;
    localparam int FracBits    = 30;
    localparam int QuotWidth   = FracBits + 1;
    localparam int RemWidth    = CompWidth + FracBits + 1;
    localparam int RootStages  = CompWidth;
    localparam int DivStages   = QuotWidth;
    localparam int NumLanes    = 3;

    typedef logic [CompWidth-1:0] comp_t;
    typedef logic [SqWidth-1:0]   sq_t;

    typedef struct packed {
        logic [NumLanes-1:0][CompWidth-1:0] mag;
        logic [NumLanes-1:0]                neg;
    } side_t;

    typedef struct packed {
        logic  vld;
        logic  err;
        comp_t len;
    } div_ctrl_t;

endpackage

### rtl/vn_sq_lane.sv
// One component lane: absolute value and exact square, registered.
// Depends on vn_pkg.
module vn_sq_lane (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [31:0]    comp,
    output vn_pkg::comp_t         mag,
    output logic                  neg,
    output vn_pkg::sq_t           sq
);
    import vn_pkg::*;

    comp_t mag_reg;
    logic  neg_reg;
    sq_t   sq_reg;
    comp_t abs_val;

    assign abs_val = comp[CompWidth-1] ? comp_t'(-comp) : comp_t'(comp);

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= abs_val;
            neg_reg <= comp[CompWidth-1];
            sq_reg  <= SqWidth'(abs_val) * SqWidth'(abs_val);
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
    assign sq  = sq_reg;

endmodule

### rtl/vn_sqrt.sv
// Sum of squares and a bit-per-stage pipelined integer square root.
// Carries the lane side data alongside. Depends on vn_pkg.
module vn_sqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_vld,
    input  logic [2:0][63:0]             sq,
    input  vn_pkg::side_t                side_in,
    output logic                         out_vld,
    output vn_pkg::comp_t                len,
    output vn_pkg::side_t                side_out
);
    import vn_pkg::*;

    logic  vld_reg  [0:RootStages];
    sq_t   rem_reg  [0:RootStages];
    comp_t root_reg [0:RootStages];
    side_t side_reg [0:RootStages];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= sq[0] + sq[1] + sq[2];
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 0; j < RootStages; j++) begin : g_stage
        localparam int K = RootStages - 1 - j;
        logic [SqWidth+1:0] trial;
        logic [SqWidth+1:0] rem_ext;
        logic               take;

        assign trial   = ({(SqWidth+2-CompWidth)'(0), root_reg[j]} << (K + 1))
                         | ((SqWidth+2)'(1) << (2 * K));
        assign rem_ext = {2'b00, rem_reg[j]};
        assign take    = rem_ext >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                vld_reg[j+1] <= vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? SqWidth'(rem_ext - trial) : rem_reg[j];
                root_reg[j+1] <= take ? (root_reg[j] | (comp_t'(1) << K)) : root_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_vld  = vld_reg[RootStages];
    assign len      = root_reg[RootStages];
    assign side_out = side_reg[RootStages];

endmodule

### rtl/vn_div_lane.sv
// One division lane: rounded restoring division of |component| * 2^30 by the length,
// one quotient bit per stage, then saturation and sign. Depends on vn_pkg.
module vn_div_lane (
    input  logic               aclk,
    input  logic               en,
    input  vn_pkg::comp_t      mag,
    input  logic               neg,
    input  vn_pkg::comp_t      len,
    output logic signed [31:0] unit
);
    import vn_pkg::*;

    localparam logic [QuotWidth-1:0] UnitOne = QuotWidth'(1) << FracBits;

    logic [RemWidth-1:0]  rem_reg [0:DivStages];
    logic [QuotWidth-1:0] q_reg   [0:DivStages];
    comp_t                len_reg [0:DivStages];
    logic                 neg_reg [0:DivStages];
    logic [QuotWidth-1:0] q_sat;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {1'b0, mag, FracBits'(0)} + RemWidth'(len >> 1);
            q_reg[0]   <= '0;
            len_reg[0] <= len;
            neg_reg[0] <= neg;
        end
    end

    for (genvar j = 0; j < DivStages; j++) begin : g_stage
        localparam int I = DivStages - 1 - j;
        logic [RemWidth-1:0] shifted;
        logic                take;

        assign shifted = RemWidth'(len_reg[j]) << I;
        assign take    = rem_reg[j] >= shifted;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= take ? rem_reg[j] - shifted : rem_reg[j];
                q_reg[j+1]   <= take ? (q_reg[j] | (QuotWidth'(1) << I)) : q_reg[j];
                len_reg[j+1] <= len_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    assign q_sat = (q_reg[DivStages] > UnitOne) ? UnitOne : q_reg[DivStages];
    assign unit  = neg_reg[DivStages] ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

endmodule

### rtl/vector3_normalizer.sv
// Top level of the 3D vector normalizer: square lanes, square root pipeline,
// division lanes and the merging output register. Depends on vn_pkg and all rtl but vn_checker.
//
// Usage:
//   Input channel s_*: one transaction carries a vector of three signed Q16.16
//   components. Result channel m_*: one transaction per vector with the Q1.30
//   unit vector, the Q16.16 length and null_error.
//   Configuration channel cfg_*: writes the 17-bit min_magnitude threshold
//   (reset value 1); it is always ready and should be written while idle.
//   There are 67 register stages from input to result: one squaring stage, one
//   summing stage, 32 square root stages (one root bit each), 31 division stages
//   (one quotient bit each, plus a setup stage) and the output register.
//   Throughput is one vector per cycle; the pipeline advances whenever the
//   output register is empty or being taken.
//   A vector whose length is zero or below the threshold gives zero components
//   and null_error high; the length is still reported.
//   Reset clears all stage valid bits and the output valid and sets the
//   threshold to 1. When the receiver stalls, the whole pipeline holds and
//   s_ready drops until the output register is taken.
module vector3_normalizer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_comp_x,
    input  logic signed [31:0] s_comp_y,
    input  logic signed [31:0] s_comp_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_unit_x,
    output logic signed [31:0] m_unit_y,
    output logic signed [31:0] m_unit_z,
    output logic [31:0]        m_length,
    output logic               m_null_error,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [16:0]        cfg_min_magnitude
);
    import vn_pkg::*;

    logic                    en;
    logic [ThreshWidth-1:0]  thresh_reg;
    logic                    sq_vld_reg;
    logic [NumLanes-1:0][CompWidth-1:0] sq_comp;
    side_t                   sq_side;
    logic [NumLanes-1:0][SqWidth-1:0]   sq_val;
    logic                    rt_vld;
    comp_t                   rt_len;
    side_t                   rt_side;
    div_ctrl_t               ctrl_reg [0:DivStages];
    div_ctrl_t               ctrl_next;
    logic [NumLanes-1:0][CompWidth-1:0] unit;
    logic                    m_valid_reg;
    logic [NumLanes-1:0][CompWidth-1:0] unit_reg;
    comp_t                   length_reg;
    logic                    err_reg;

    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    assign sq_comp[0] = s_comp_x;
    assign sq_comp[1] = s_comp_y;
    assign sq_comp[2] = s_comp_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= ThreshWidth'(1);
        end else if (cfg_valid) begin
            thresh_reg <= cfg_min_magnitude;
        end
    end

    for (genvar l = 0; l < NumLanes; l++) begin : g_sq
        vn_sq_lane u_sq (
            .aclk (aclk),
            .en   (en),
            .comp (sq_comp[l]),
            .mag  (sq_side.mag[l]),
            .neg  (sq_side.neg[l]),
            .sq   (sq_val[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg <= s_valid;
        end
    end

    vn_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (sq_vld_reg),
        .sq       (sq_val),
        .side_in  (sq_side),
        .out_vld  (rt_vld),
        .len      (rt_len),
        .side_out (rt_side)
    );

    always_comb begin
        ctrl_next.vld = rt_vld;
        ctrl_next.err = (rt_len == '0) || (rt_len < CompWidth'(thresh_reg));
        ctrl_next.len = rt_len;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= DivStages; i++) begin
                ctrl_reg[i].vld <= 1'b0;
            end
        end else if (en) begin
            ctrl_reg[0] <= ctrl_next;
            for (int i = 0; i < DivStages; i++) begin
                ctrl_reg[i+1] <= ctrl_reg[i];
            end
        end
    end

    for (genvar l = 0; l < NumLanes; l++) begin : g_div
        vn_div_lane u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (rt_side.mag[l]),
            .neg  (rt_side.neg[l]),
            .len  (rt_len),
            .unit (unit[l])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ctrl_reg[DivStages].vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < NumLanes; l++) begin
                unit_reg[l] <= ctrl_reg[DivStages].err ? '0 : unit[l];
            end
            length_reg <= ctrl_reg[DivStages].len;
            err_reg    <= ctrl_reg[DivStages].err;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_unit_x     = unit_reg[0];
    assign m_unit_y     = unit_reg[1];
    assign m_unit_z     = unit_reg[2];
    assign m_length     = length_reg;
    assign m_null_error = err_reg;

endmodule

### rtl/vn_checker.sv
// Port-level checks for the 3D vector normalizer, bound to the top level.
// Depends on the ports of vector3_normalizer only.
module vn_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_unit_x,
    input logic signed [31:0] m_unit_y,
    input logic signed [31:0] m_unit_z,
    input logic [31:0]        m_length,
    input logic               m_null_error
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_length))
        else $error("Result transaction dropped or changed while stalled.");

    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_null_error |-> m_unit_x == 0 && m_unit_y == 0 && m_unit_z == 0)
        else $error("Null result carries nonzero components.");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_null_error |-> m_length != 0)
        else $error("Normalized result with zero length.");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_unit_x <= 32'sh4000_0000 && m_unit_x >= -32'sh4000_0000)
        else $error("Unit x component outside the Q1.30 range.");

endmodule

bind vector3_normalizer vn_checker u_vn_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_unit_x     (m_unit_x),
    .m_unit_y     (m_unit_y),
    .m_unit_z     (m_unit_z),
    .m_length     (m_length),
    .m_null_error (m_null_error)
);

### test/vector3_normalizer_tb.sv
// Testbench for the 3D vector normalizer: directed and random vectors under several
// handshake phases, checked by a scoreboard class. Depends on rtl/vector3_normalizer.sv.
`timescale 1ns / 1ps

class unit_vector_board;
    logic [16:0] threshold;
    logic [31:0] exp_x[$], exp_y[$], exp_z[$], exp_len[$];
    logic        exp_err[$];
    int          failures;

    function new();
        threshold = 17'd1;
        failures  = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function logic [31:0] scale(logic [63:0] mag, logic neg, logic [63:0] len);
        logic [63:0] q;
        q = ((mag << 30) + (len >> 1)) / len;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        if (neg) q = -q;
        return q[31:0];
    endfunction

    function void note_vector(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        logic [63:0] mx, my, mz, len;
        mx  = cx[31] ? {32'd0, -cx} : {32'd0, cx};
        my  = cy[31] ? {32'd0, -cy} : {32'd0, cy};
        mz  = cz[31] ? {32'd0, -cz} : {32'd0, cz};
        len = isqrt(mx * mx + my * my + mz * mz) & 64'hFFFF_FFFF;
        exp_len.push_back(len[31:0]);
        if (len == 0 || len < {47'd0, threshold}) begin
            exp_x.push_back(0);
            exp_y.push_back(0);
            exp_z.push_back(0);
            exp_err.push_back(1'b1);
        end else begin
            exp_x.push_back(scale(mx, cx[31], len));
            exp_y.push_back(scale(my, cy[31], len));
            exp_z.push_back(scale(mz, cz[31], len));
            exp_err.push_back(1'b0);
        end
    endfunction

    function void check_result(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                               logic [31:0] len, logic err);
        logic [31:0] ex, ey, ez, el;
        logic        ee;
        if (exp_len.size() == 0) begin
            $error("unexpected result transaction");
            failures++;
            return;
        end
        ex = exp_x.pop_front();
        ey = exp_y.pop_front();
        ez = exp_z.pop_front();
        el = exp_len.pop_front();
        ee = exp_err.pop_front();
        if (ux !== ex) begin $error("unit_x exp %h got %h", ex, ux); failures++; end
        if (uy !== ey) begin $error("unit_y exp %h got %h", ey, uy); failures++; end
        if (uz !== ez) begin $error("unit_z exp %h got %h", ez, uz); failures++; end
        if (len !== el) begin $error("length exp %h got %h", el, len); failures++; end
        if (err !== ee) begin $error("null_error exp %b got %b", ee, err); failures++; end
    endfunction
endclass

module testbench;
    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_comp_x = 0, s_comp_y = 0, s_comp_z = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_unit_x, m_unit_y, m_unit_z;
    logic [31:0]        m_length;
    logic               m_null_error;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [16:0]        cfg_min_magnitude = 0;

    unit_vector_board board = new();
    int  send_idle = 0;
    int  recv_stall = 0;
    int  hold_cycles = 0;
    bit  stim_done = 0;

    vector3_normalizer i_dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("vector3_normalizer: mismatch");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_unit_x, m_unit_y, m_unit_z, m_length, m_null_error);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [31:0] pick_comp();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(3) - 2;
            3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            4: return 32'($urandom_range(255)) << $urandom_range(24);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vector(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_comp_x <= cx;
        s_comp_y <= cy;
        s_comp_z <= cz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_vector(cx, cy, cz);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.exp_len.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [16:0] value);
        cfg_valid         <= 1'b1;
        cfg_min_magnitude <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.threshold = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        int idle_send[4] = '{0, 86, 0, 19};
        int idle_recv[4] = '{0, 0, 86, 19};
        logic [16:0] thr[4] = '{17'd0, 17'd65536, 17'd1, 17'd300};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_vector(0, 0, 0);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_vector(32'h8000_0000, 0, 0);
        send_vector(0, 32'h7FFF_FFFF, 0);
        send_vector(0, 0, 32'hFFFF_FFFF);
        send_vector(1, 0, 0);
        send_vector(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_vector(3, 4, 0);
        drain();
        write_threshold(17'd0);
        send_vector(0, 0, 0);
        send_vector(0, 0, 1);
        drain();
        write_threshold(17'd65536);
        send_vector(32'h0000_FFFF, 0, 0);
        send_vector(32'h0001_0000, 0, 0);
        send_vector(0, 32'hFFFF_0001, 0);
        drain();
        hold_cycles = 200;
        for (int i = 0; i < 120; i++) send_vector(pick_comp(), pick_comp(), pick_comp());
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_threshold(thr[ph]);
            send_idle  = idle_send[ph];
            recv_stall = idle_recv[ph];
            for (int i = 0; i < 220; i++)
                send_vector(pick_comp(), pick_comp(), pick_comp());
        end
        send_idle  = 0;
        recv_stall = 0;
        drain();
        if (board.failures == 0)
            $display("vector3_normalizer: match");
        else
            $display("vector3_normalizer: mismatch");
        $finish;
    end
endmodule
